FILE: rtl/core/vsa_pkg.sv
// Package for the vector signed angle block: widths, the arctangent table
// and small helpers shared by the pipeline cells. No dependencies.
package vsa_pkg;
    localparam int MaxStages  = 32;
    localparam int AngW       = 27;   // internal angle, units of pi/2^24, signed
    localparam int DotW       = 36;
    localparam int CrsW       = 34;
    localparam int SqW        = 64;
    localparam int RootW      = 32;
    localparam int CordW      = 56;   // x/y datapath of the CORDIC
    localparam logic signed [AngW-1:0] HalfPi = 27'sd8388608;
    localparam logic signed [AngW-1:0] FullPi = 27'sd16777216;

    typedef logic signed [AngW-1:0] ang_t;
    typedef logic signed [CordW-1:0] cord_t;

    function automatic ang_t atan_entry(input logic [4:0] idx);
        ang_t r;
        r = '0;
        case (idx)
            5'd0:  r = 27'sd4194304;
            5'd1:  r = 27'sd2476042;
            5'd2:  r = 27'sd1308273;
            5'd3:  r = 27'sd664100;
            5'd4:  r = 27'sd333339;
            5'd5:  r = 27'sd166832;
            5'd6:  r = 27'sd83436;
            5'd7:  r = 27'sd41721;
            5'd8:  r = 27'sd20861;
            5'd9:  r = 27'sd10430;
            5'd10: r = 27'sd5215;
            5'd11: r = 27'sd2608;
            5'd12: r = 27'sd1304;
            5'd13: r = 27'sd652;
            5'd14: r = 27'sd326;
            5'd15: r = 27'sd163;
            5'd16: r = 27'sd81;
            5'd17: r = 27'sd41;
            5'd18: r = 27'sd20;
            5'd19: r = 27'sd10;
            5'd20: r = 27'sd5;
            5'd21: r = 27'sd3;
            5'd22: r = 27'sd1;
            5'd23: r = 27'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Item state carried down the chain beside the datapath.
    typedef struct packed {
        logic        zero_crs;   // cross product zero
        logic        neg_dot;
        logic        neg_cz;
    } tag_t;
endpackage

FILE: rtl/core/vector_signed_angle.sv
// Signed angle between two 3-D vectors: products, integer square root of
// |BxA|^2 and a CORDIC atan2, all as one row of pipeline cells.
// A request passes the product stages, the square-root cells, the CORDIC cells and the output register, in that order.
// Throughput: one request per cycle; busy is always low.
// Reset clears only the valid chain; the receiver cannot stall the strobe.
// Depends on vsa_pkg, vsa_sqrt_cell and vsa_cordic_cell.
module vector_signed_angle
    import vsa_pkg::*;
#(
    parameter int CORDIC_STAGES = 18
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  ax,
    input  logic signed [15:0]  ay,
    input  logic signed [15:0]  az,
    input  logic signed [15:0]  bx,
    input  logic signed [15:0]  by,
    input  logic signed [15:0]  bz,
    output logic                done,
    output logic signed [16:0]  angle
);
    localparam int Stages = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;

    // A fully pipelined chain never holds requests off.
    assign busy = 1'b0;

    // ---- stage 1: the nine products ----
    logic signed [31:0] p_axbx_reg, p_ayby_reg, p_azbz_reg;
    logic signed [31:0] p_byaz_reg, p_aybz_reg, p_bzax_reg;
    logic signed [31:0] p_azbx_reg, p_bxay_reg, p_axby_reg;
    logic               v1_reg;

    always_ff @(posedge clk)
    begin
        p_axbx_reg <= ax * bx;
        p_ayby_reg <= ay * by;
        p_azbz_reg <= az * bz;
        p_byaz_reg <= by * az;
        p_aybz_reg <= ay * bz;
        p_bzax_reg <= bz * ax;
        p_azbx_reg <= az * bx;
        p_bxay_reg <= bx * ay;
        p_axby_reg <= ax * by;
    end

    // ---- stage 2: dot and cross components ----
    logic signed [DotW-1:0] dot2_reg;
    logic signed [CrsW-1:0] cx2_reg, cy2_reg, cz2_reg;
    logic                   v2_reg;

    always_ff @(posedge clk)
    begin
        dot2_reg <= DotW'(p_axbx_reg) + DotW'(p_ayby_reg) + DotW'(p_azbz_reg);
        cx2_reg  <= CrsW'(p_byaz_reg) - CrsW'(p_aybz_reg);
        cy2_reg  <= CrsW'(p_bzax_reg) - CrsW'(p_azbx_reg);
        cz2_reg  <= CrsW'(p_bxay_reg) - CrsW'(p_axby_reg);
    end

    // ---- stage 3: squares of the cross magnitudes ----
    logic [CrsW-1:0]        mx3, my3, mz3;
    logic [SqW-1:0]         sqx3_reg, sqy3_reg, sqz3_reg;
    logic signed [DotW-1:0] dot3_reg;
    logic                   ncz3_reg, v3_reg;

    assign mx3 = cx2_reg[CrsW-1] ? CrsW'(-cx2_reg) : cx2_reg;
    assign my3 = cy2_reg[CrsW-1] ? CrsW'(-cy2_reg) : cy2_reg;
    assign mz3 = cz2_reg[CrsW-1] ? CrsW'(-cz2_reg) : cz2_reg;

    // Each magnitude is below 2^32, so a 32x32 square.
    always_ff @(posedge clk)
    begin
        sqx3_reg <= SqW'(mx3[31:0]) * SqW'(mx3[31:0]);
        sqy3_reg <= SqW'(my3[31:0]) * SqW'(my3[31:0]);
        sqz3_reg <= SqW'(mz3[31:0]) * SqW'(mz3[31:0]);
        dot3_reg <= dot2_reg;
        ncz3_reg <= cz2_reg[CrsW-1];
    end

    // ---- stage 4: sum of squares ----
    logic [SqW-1:0]         s2_4_reg;
    logic signed [DotW-1:0] dot4_reg;
    logic                   ncz4_reg, v4_reg;

    always_ff @(posedge clk)
    begin
        s2_4_reg <= sqx3_reg + sqy3_reg + sqz3_reg;
        dot4_reg <= dot3_reg;
        ncz4_reg <= ncz3_reg;
    end

    // ---- stage 5: normalize shift n (largest n<=16 with s2*4^n < 2^62) ----
    logic [4:0]             n5;
    logic [SqW-1:0]         s2n5_reg;
    logic [4:0]             n5_reg;
    logic signed [DotW-1:0] dot5_reg;
    tag_t                   tag5_reg;
    logic                   v5_reg;

    always_comb
    begin
        n5 = 5'd16;
        for (int k = 15; k >= 0; k--)
        begin
            if ((s2_4_reg >> (60 - 2 * k)) != 64'd0)
                n5 = 5'(k);
        end
        if ((s2_4_reg >> 60) != 64'd0)
            n5 = 5'd0;
    end

    always_ff @(posedge clk)
    begin
        s2n5_reg          <= s2_4_reg << (2 * n5);
        n5_reg            <= n5;
        dot5_reg          <= dot4_reg;
        tag5_reg.zero_crs <= (s2_4_reg == 64'd0);
        tag5_reg.neg_dot  <= dot4_reg[DotW-1];
        tag5_reg.neg_cz   <= ncz4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---- square-root chain: 32 cells, one root bit each ----
    logic                   sq_vld  [0:RootW];
    logic [SqW-1:0]         sq_rem  [0:RootW];
    logic [RootW-1:0]       sq_root [0:RootW];
    logic [DotW-1:0]        sq_dot  [0:RootW];
    logic [4:0]             sq_n    [0:RootW];
    tag_t                   sq_tag  [0:RootW];

    assign sq_vld[0]  = v5_reg;
    assign sq_rem[0]  = s2n5_reg;
    assign sq_root[0] = '0;
    assign sq_dot[0]  = dot5_reg;
    assign sq_n[0]    = n5_reg;
    assign sq_tag[0]  = tag5_reg;

    for (genvar g = 0; g < RootW; g++)
    begin : g_sqrt
        vsa_sqrt_cell #(.BitIdx(RootW - 1 - g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (sq_vld[g]),
            .in_rem  (sq_rem[g]),
            .in_root (sq_root[g]),
            .in_dot  (sq_dot[g]),
            .in_n    (sq_n[g]),
            .in_tag  (sq_tag[g]),
            .out_vld (sq_vld[g+1]),
            .out_rem (sq_rem[g+1]),
            .out_root(sq_root[g+1]),
            .out_dot (sq_dot[g+1]),
            .out_n   (sq_n[g+1]),
            .out_tag (sq_tag[g+1])
        );
    end

    // ---- CORDIC entry: scale dot, pre-rotate by -pi/2 when dot is negative ----
    cord_t x_pre, y_pre, xd;
    ang_t  z_pre;

    assign xd = cord_t'(signed'(sq_dot[RootW])) <<< sq_n[RootW];

    always_comb
    begin
        if (sq_tag[RootW].neg_dot)
        begin
            x_pre = cord_t'({1'b0, sq_root[RootW]});
            y_pre = -xd;
            z_pre = HalfPi;
        end
        else
        begin
            x_pre = xd;
            y_pre = cord_t'({1'b0, sq_root[RootW]});
            z_pre = '0;
        end
    end

    logic   cd_vld [0:Stages];
    cord_t  cd_x   [0:Stages];
    cord_t  cd_y   [0:Stages];
    ang_t   cd_z   [0:Stages];
    tag_t   cd_tag [0:Stages];

    assign cd_vld[0] = sq_vld[RootW];
    assign cd_x[0]   = x_pre;
    assign cd_y[0]   = y_pre;
    assign cd_z[0]   = z_pre;
    assign cd_tag[0] = sq_tag[RootW];

    for (genvar g = 0; g < Stages; g++)
    begin : g_cordic
        vsa_cordic_cell #(.Idx(g)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .in_vld (cd_vld[g]),
            .in_x   (cd_x[g]),
            .in_y   (cd_y[g]),
            .in_z   (cd_z[g]),
            .in_tag (cd_tag[g]),
            .out_vld(cd_vld[g+1]),
            .out_x  (cd_x[g+1]),
            .out_y  (cd_y[g+1]),
            .out_z  (cd_z[g+1]),
            .out_tag(cd_tag[g+1])
        );
    end

    // ---- output: clamp, round to pi/32768, apply sign ----
    ang_t               z_clamp, z_round;
    logic signed [16:0] res_mag, res_next;
    logic signed [16:0] angle_reg;
    logic               done_reg;

    always_comb
    begin
        z_clamp = cd_z[Stages];
        if (z_clamp < 0)
            z_clamp = '0;
        if (z_clamp > FullPi)
            z_clamp = FullPi;
        z_round = z_clamp + ang_t'(256);
        res_mag = 17'(z_round >>> 9);
        if (cd_tag[Stages].zero_crs)
            res_next = cd_tag[Stages].neg_dot ? 17'sd32768 : 17'sd0;
        else if (cd_tag[Stages].neg_cz)
            res_next = -res_mag;
        else
            res_next = res_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cd_vld[Stages];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= res_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

    // An accepted request sets the product-stage valid in the next cycle.
    a_v1: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> v1_reg)
        else $error("product stage lost a request");
    // Valid only follows a request.
    a_v2: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("sum stage valid without a request");
    // Zero cross product yields only 0 or pi.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cd_vld[Stages] && cd_tag[Stages].zero_crs) |=>
        (angle == 17'sd0 || angle == 17'sd32768))
        else $error("zero cross product gave a non-axis angle");
    // Strobe follows the end of the CORDIC chain.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cd_vld[Stages]))
        else $error("strobe without a finished item");
endmodule

FILE: rtl/core/vsa_sqrt_cell.sv
// One cell of the pipelined integer square root: one result bit per cell.
// Depends on vsa_pkg.
module vsa_sqrt_cell
    import vsa_pkg::*;
#(
    parameter int BitIdx = 31
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [SqW-1:0]    in_rem,
    input  logic [RootW-1:0]  in_root,
    input  logic [DotW-1:0]   in_dot,
    input  logic [4:0]        in_n,
    input  tag_t              in_tag,
    output logic              out_vld,
    output logic [SqW-1:0]    out_rem,
    output logic [RootW-1:0]  out_root,
    output logic [DotW-1:0]   out_dot,
    output logic [4:0]        out_n,
    output tag_t              out_tag
);
    // Restoring digit step: try root bit BitIdx.
    logic [SqW-1:0]   trial;
    logic [RootW-1:0] rem_root_next;
    logic [SqW-1:0]   rem_next;
    logic             vld_reg;

    always_comb
    begin
        trial = ({32'd0, in_root} << (BitIdx + 1)) | (64'd1 << (2 * BitIdx));
        if (in_rem >= trial)
        begin
            rem_next      = in_rem - trial;
            rem_root_next = in_root | (32'd1 << BitIdx);
        end
        else
        begin
            rem_next      = in_rem;
            rem_root_next = in_root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        out_rem  <= rem_next;
        out_root <= rem_root_next;
        out_dot  <= in_dot;
        out_n    <= in_n;
        out_tag  <= in_tag;
    end

    assign out_vld = vld_reg;
endmodule

FILE: rtl/core/vsa_cordic_cell.sv
// One CORDIC vectoring cell: one micro-rotation by atan(2^-Idx) per cell.
// Depends on vsa_pkg.
module vsa_cordic_cell
    import vsa_pkg::*;
#(
    parameter int Idx = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_vld,
    input  cord_t  in_x,
    input  cord_t  in_y,
    input  ang_t   in_z,
    input  tag_t   in_tag,
    output logic   out_vld,
    output cord_t  out_x,
    output cord_t  out_y,
    output ang_t   out_z,
    output tag_t   out_tag
);
    cord_t xs, ys;
    ang_t  step;
    logic  vld_reg;

    assign xs   = in_x >>> Idx;
    assign ys   = in_y >>> Idx;
    assign step = atan_entry(5'(Idx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (!in_y[CordW-1])
        begin
            out_x <= in_x + ys;
            out_y <= in_y - xs;
            out_z <= in_z + step;
        end
        else
        begin
            out_x <= in_x - ys;
            out_y <= in_y + xs;
            out_z <= in_z - step;
        end
        out_tag <= in_tag;
    end

    assign out_vld = vld_reg;
endmodule

FILE: verif/vector_signed_angle_test.sv
// Testbench for vector_signed_angle: drives vector pairs, predicts each signed
// angle with a local CORDIC atan2 model and compares every done strobe.
// Depends on the vector_signed_angle RTL and vsa_pkg.
module vector_signed_angle_test;
    import vsa_pkg::*;

    localparam int NumStages = 18;
    localparam int Latency   = 5 + 32 + NumStages + 1;
    localparam int RandItems = 1500;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] ax, ay, az, bx, by, bz;
    logic               done;
    logic signed [16:0] angle;

    int mismatch_count;

    vector_signed_angle #(.CORDIC_STAGES(NumStages)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .done(done), .angle(angle)
    );

    task automatic report(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Table of arctangents in units of pi/2^24.
    function automatic longint arctan_step(input int i);
        longint t [0:23] = '{4194304, 2476042, 1308273, 664100, 333339, 166832,
                             83436, 41721, 20861, 10430, 5215, 2608, 1304, 652,
                             326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        if (i > 23)
            return 0;
        return t[i];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos >>= 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v -= root + bitpos;
                root = (root >> 1) + bitpos;
            end
            else
                root >>= 1;
            bitpos >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [16:0] signed_angle(
        input logic signed [15:0] pax, pay, paz, pbx, pby, pbz);
        longint dotp, crx, cry, crz, x, y, z, t, xs, ys, res;
        longint unsigned mag2;
        int shift;
        dotp = pax * pbx + pay * pby + paz * pbz;
        crx = longint'(pby) * paz - longint'(pay) * pbz;
        cry = longint'(pbz) * pax - longint'(paz) * pbx;
        crz = longint'(pbx) * pay - longint'(pax) * pby;
        dotp = longint'(pax) * pbx + longint'(pay) * pby + longint'(paz) * pbz;
        mag2 = crx * crx + cry * cry + crz * crz;
        if (mag2 == 0)
            return (dotp < 0) ? 17'sd32768 : 17'sd0;
        shift = 0;
        while (shift < 16 && (mag2 >> (60 - 2 * shift)) == 0)
            shift++;
        y = longint'(int_sqrt(mag2 << (2 * shift)));
        x = dotp <<< shift;
        z = 0;
        // Negative dot: rotate by -pi/2 first so CORDIC converges.
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = 8388608;
        end
        for (int i = 0; i < NumStages && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += arctan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= arctan_step(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > 16777216)
            z = 16777216;
        res = (z + 256) >>> 9;
        if (crz < 0)
            res = -res;
        return res[16:0];
    endfunction

    class angle_scoreboard;
        logic signed [16:0] pending_angles[$];

        function void note_request(input logic signed [15:0] pax, pay, paz,
                                   pbx, pby, pbz);
            pending_angles.push_back(signed_angle(pax, pay, paz, pbx, pby, pbz));
        endfunction

        task check_result(input logic signed [16:0] got);
            logic signed [16:0] want;
            if (pending_angles.size() == 0)
            begin
                report($sformatf("unexpected result angle=%0d", got));
                return;
            end
            want = pending_angles.pop_front();
            if (got !== want)
                report($sformatf("angle got %0d want %0d", got, want));
        endtask
    endclass

    angle_scoreboard board;
    bit idle_on;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Sample accepted requests and results at the edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(ax, ay, az, bx, by, bz);
        if (rst_n && done)
            board.check_result(angle);
    end

    // Send one request: hold start until accepted, then optionally idle.
    task automatic send_request(input logic signed [15:0] pax, pay, paz,
                                pbx, pby, pbz);
        int gap;
        start <= 1'b1;
        ax <= pax; ay <= pay; az <= paz;
        bx <= pbx; by <= pby; bz <= pbz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] pick_component();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return 16'(signed'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic signed [15:0] v[6];
        int k;
        foreach (v[i])
            v[i] = pick_component();
        k = $urandom_range(0, 9);
        // Drive parallel, antiparallel and coplanar pairs to hit the edges.
        if (k == 0)
        begin
            v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
        end
        else if (k == 1)
        begin
            v[3] = -v[0]; v[4] = -v[1]; v[5] = -v[2];
        end
        else if (k == 2)
        begin
            v[2] = 0; v[5] = 0;
        end
        send_request(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial
    begin
        int waited;
        board = new();
        mismatch_count = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        ax = '0; ay = '0; az = '0; bx = '0; by = '0; bz = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vectors, parallel, antiparallel, perpendicular both
        // ways, extremes of each field, negative dot.
        send_request(0, 0, 0, 0, 0, 0);
        send_request(1, 2, 3, 2, 4, 6);
        send_request(1, 2, 3, -1, -2, -3);
        send_request(0, 1, 0, 1, 0, 0);
        send_request(1, 0, 0, 0, 1, 0);
        send_request(-1, 1, 0, 1, 0, 0);
        send_request(-1, -1, 0, 1, 0, 0);
        send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(16'sh8000, 16'sh7fff, 0, 16'sh7fff, 16'sh8000, 0);
        send_request(16'sh8000, 0, 0, 0, 16'sh8000, 0);
        send_request(16'sh7fff, 1, 0, 16'sh7fff, 0, 0);
        send_request(16'sh7fff, -1, 0, 16'sh7fff, 0, 0);
        send_request(0, 0, 16'sh7fff, 0, 16'sh8000, 0);
        send_request(-1, 0, 0, 1, 0, 0);
        send_request(-16'sd1000, 1, 0, 1000, 0, 0);
        send_request(0, 0, 0, 5, -7, 9);
        send_request(16'shffff, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'shffff);

        for (int n = 0; n < RandItems; n++)
        begin
            if (n > RandItems - 200)
                idle_on = 1'b0;
            send_random();
        end
        start <= 1'b0;

        waited = 0;
        while (board.pending_angles.size() != 0 && waited < 10 * Latency)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (Latency + 4) @(posedge clk);
        if (mismatch_count == 0 && board.pending_angles.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
